### hw/rtl/altitude_rise_run_detector_defines.svh
// ----------------------------------------------------------------------------
// Altitude rise run detector assertion macros
// Shared assertion macros, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_RISE_RUN_DETECTOR_DEFINES_SVH
`define ALTITUDE_RISE_RUN_DETECTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ARRD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ARRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ARRD_ASSERT_SAME(lbl, ante, cons, msg)
`define ARRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/ardr_pkg.sv
// ----------------------------------------------------------------------------
// Altitude rise run detector package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package ardr_pkg;

	localparam int SAMPLE_W = 32;
	localparam int THR_W = 20;
	localparam int RUN_W = 6;
	localparam int REG_IDX_W = 1;

	localparam logic [THR_W-1:0] THR_RESET = 20'd4000;
	localparam logic [RUN_W-1:0] RUN_RESET = 6'd10;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RISE_THRESHOLD = 1'b0,
		REG_RUN_LENGTH     = 1'b1
	} ardr_reg_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic bound;
		logic issue;
		logic emit;
	} ardr_cmd_t;

	typedef struct packed {
		logic empty;
		logic last_issue;
		logic pipe_busy;
		logic out_busy;
	} ardr_sts_t;

endpackage

### hw/rtl/ardr_ctrl.sv
// ----------------------------------------------------------------------------
// Altitude rise run detector controller
// Sequences one word through ring update, bound setup, scan and result.
// ----------------------------------------------------------------------------
module ardr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               altitude_valid,
	output logic               altitude_stall,
	input  ardr_pkg::ardr_sts_t sts,
	output ardr_pkg::ardr_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_OLD   = 6'b000010,
		S_BOUND = 6'b000100,
		S_SCAN  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (altitude_valid) begin
					cmd.accept = 1'b1;
					state_d = S_OLD;
				end
			end
			S_OLD: begin
				cmd.update = 1'b1;
				state_d = S_BOUND;
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_d = sts.empty ? S_DONE : S_SCAN;
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign altitude_stall = (state_q != S_IDLE);

endmodule

### hw/rtl/ardr_dp.sv
// ----------------------------------------------------------------------------
// Altitude rise run detector datapath
// Sample ring, running sum and count, scan pipeline and result register.
// ----------------------------------------------------------------------------
module ardr_dp #(
	parameter int DEPTH = 60
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ardr_pkg::ardr_cmd_t                  cmd,
	output ardr_pkg::ardr_sts_t                  sts,
	input  logic signed [ardr_pkg::SAMPLE_W-1:0] altitude,
	input  logic                                 cfg_valid,
	input  logic [ardr_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [ardr_pkg::THR_W-1:0]           cfg_data,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 launch_now,
	output logic                                 launch_latched,
	output logic                                 data_present
);

	localparam int AW = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = ardr_pkg::SAMPLE_W + CNT_W + 1;
	localparam logic signed [CMP_W-1:0] DEPTH_S = CMP_W'(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [ardr_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]              vld_q;
	logic [ardr_pkg::SAMPLE_W-1:0] rd_q;
	logic                          rd_vld_q;
	logic [AW-1:0]                 rd_addr;

	logic signed [ardr_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [ardr_pkg::SAMPLE_W-1:0] rd_eff;
	logic [AW-1:0]                        wp_q;
	logic [AW-1:0]                        wp_next;
	logic signed [CMP_W-1:0]              sum_q;
	logic [CNT_W-1:0]                     cnt_q;
	logic [CNT_W-1:0]                     cnt_next;

	logic [ardr_pkg::THR_W-1:0] thr_q;
	logic [ardr_pkg::RUN_W-1:0] run_len_q;
	logic [ardr_pkg::RUN_W-1:0] need;

	logic signed [CMP_W-1:0]    bound_q;
	logic [AW-1:0]              scan_addr_q;
	logic [AW-1:0]              scan_cnt_q;
	logic                       pv1_q;
	logic                       pv2_q;
	logic signed [CMP_W-1:0]    prod_s2;
	logic [ardr_pkg::RUN_W-1:0] run_q;
	logic                       found_q;
	logic                       latch_q;
	logic                       hit;

	assign rd_addr = cmd.issue ? scan_addr_q : wp_q;
	assign rd_eff = rd_vld_q ? $signed(rd_q) : '0;
	assign wp_next = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
	assign need = (run_len_q == '0) ? ardr_pkg::RUN_W'(1) : run_len_q;
	assign hit = pv2_q && (prod_s2 > bound_q);

	always_comb begin
		cnt_next = cnt_q;
		if (rd_eff != '0) begin
			cnt_next = cnt_next - 1'b1;
		end
		if (sample_q != '0) begin
			cnt_next = cnt_next + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[wp_q] <= sample_q;
		end
		rd_q <= mem[rd_addr];
		rd_vld_q <= vld_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= altitude;
		end
		if (cmd.update) begin
			scan_addr_q <= wp_next;
		end else if (cmd.issue) begin
			scan_addr_q <= (scan_addr_q == LAST_ADDR) ? '0 : scan_addr_q + 1'b1;
		end
		if (cmd.bound) begin
			bound_q <= sum_q + $signed(CMP_W'(thr_q) * CMP_W'(DEPTH));
		end
		prod_s2 <= CMP_W'(rd_eff) * DEPTH_S;
		if (cmd.emit) begin
			launch_now <= found_q;
			launch_latched <= latch_q | found_q;
			data_present <= (cnt_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wp_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			thr_q <= ardr_pkg::THR_RESET;
			run_len_q <= ardr_pkg::RUN_RESET;
			scan_cnt_q <= '0;
			pv1_q <= 1'b0;
			pv2_q <= 1'b0;
			run_q <= '0;
			found_q <= 1'b0;
			latch_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (ardr_pkg::ardr_reg_t'(cfg_index))
					ardr_pkg::REG_RISE_THRESHOLD: thr_q <= cfg_data;
					ardr_pkg::REG_RUN_LENGTH:     run_len_q <= cfg_data[ardr_pkg::RUN_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.update) begin
				vld_q[wp_q] <= 1'b1;
				wp_q <= wp_next;
				sum_q <= sum_q - CMP_W'(rd_eff) + CMP_W'(sample_q);
				cnt_q <= cnt_next;
			end
			if (cmd.bound) begin
				scan_cnt_q <= '0;
			end else if (cmd.issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			pv1_q <= cmd.issue;
			pv2_q <= pv1_q;
			if (cmd.bound) begin
				run_q <= '0;
				found_q <= 1'b0;
			end else if (hit) begin
				if ({1'b0, run_q} + 1'b1 >= {1'b0, need}) begin
					found_q <= 1'b1;
				end else begin
					run_q <= run_q + 1'b1;
				end
			end else if (pv2_q) begin
				run_q <= '0;
			end
			if (cmd.emit) begin
				latch_q <= latch_q | found_q;
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	assign sts.empty = (cnt_q == '0);
	assign sts.last_issue = (scan_cnt_q == LAST_ADDR);
	assign sts.pipe_busy = pv1_q | pv2_q;
	assign sts.out_busy = result_valid & result_stall;

endmodule

### hw/rtl/altitude_rise_run_detector.sv
// ----------------------------------------------------------------------------
// Altitude rise run detector
// Detects a launch from a run of altitude samples above the window mean.
// ----------------------------------------------------------------------------
// Each altitude word replaces the oldest of DEPTH stored samples, and the
// ring is then scanned oldest first, one stored sample per cycle through the
// single read port of the sample memory, looking for run_length consecutive
// samples above the window mean plus rise_threshold. A new word is not
// accepted until the last one has finished its scan and result, and the
// scan is skipped when every stored sample is zero. The result register
// lets a new word be taken while the last result is still waiting on
// result_stall. The configuration port is always ready.
module altitude_rise_run_detector #(
	parameter int DEPTH = 60
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 altitude_valid,
	output logic                                 altitude_stall,
	input  logic signed [ardr_pkg::SAMPLE_W-1:0] altitude,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 launch_now,
	output logic                                 launch_latched,
	output logic                                 data_present,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ardr_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [ardr_pkg::THR_W-1:0]           cfg_data
);

	`include "altitude_rise_run_detector_defines.svh"

	ardr_pkg::ardr_cmd_t cmd;
	ardr_pkg::ardr_sts_t sts;

	assign cfg_ready = 1'b1;

	ardr_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.altitude_valid (altitude_valid),
		.altitude_stall (altitude_stall),
		.sts            (sts),
		.cmd            (cmd)
	);

	ardr_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.altitude       (altitude),
		.cfg_valid      (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.launch_now     (launch_now),
		.launch_latched (launch_latched),
		.data_present   (data_present)
	);

	`ARRD_ASSERT_NEXT(a_busy_after_accept, altitude_valid && !altitude_stall, altitude_stall, "word accepted without going busy")
	`ARRD_ASSERT_SAME(a_launch_latched, result_valid && launch_now, launch_latched, "launch not latched")
	`ARRD_ASSERT_SAME(a_launch_needs_data, result_valid && launch_now, data_present, "launch on empty window")

endmodule
